>>> src/rotation_matrix_to_euler_macros.svh
// Assertion macros shared by the rotation matrix to Euler angle block.
// Each macro expects signals named clk and arst_n in the scope of its use.
`ifndef ROTATION_MATRIX_TO_EULER_MACROS_SVH
`define ROTATION_MATRIX_TO_EULER_MACROS_SVH

// Implication checked in the same cycle.
`define RME_ASSERT_IMP(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("rme assertion failed");

// Implication checked in the next cycle.
`define RME_ASSERT_NEXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("rme assertion failed");

`endif

>>> src/rme_pkg.sv
// Types, constants and helper functions of the rotation matrix to Euler angle block.
// Used by the square root cell, the CORDIC cell and the top level.
`timescale 1ns / 1ps

package rme_pkg;

	localparam int ELEM_W = 16;
	localparam int ANG_W = 16;
	localparam int ROOT_W = 24;
	localparam int RAD_W = 2 * ROOT_W;
	localparam int REM_W = 26;
	localparam int CV_W = 27;
	localparam int ACC_W = 26;
	localparam int ATAN_LEN = 24;
	localparam int ANGLE_LIMIT = 23040;
	localparam int QUARTER_TURN = 90 * 65536;

	typedef logic signed [ELEM_W-1:0] elem_t;

	typedef struct packed {
		elem_t m23;
		elem_t m22;
		elem_t m33;
		elem_t m32;
		elem_t m31;
		elem_t m21;
		elem_t m11;
	} elems_t;

	typedef struct packed {
		logic [RAD_W-1:0] n;
		logic [REM_W-1:0] rem;
		logic [ROOT_W-1:0] root;
	} sq_t;

	typedef struct packed {
		logic signed [CV_W-1:0] x;
		logic signed [CV_W-1:0] y;
		logic signed [ACC_W-1:0] a;
	} cord_t;

	typedef struct packed {
		logic sing;
		logic signed [ANG_W-1:0] az;
		logic signed [ANG_W-1:0] ay;
		logic signed [ANG_W-1:0] ax;
	} res_t;

	// Arctangent of 2^-i in units of 2^-16 degree.
	function automatic logic signed [ACC_W-1:0] atan_step(input int i);
		logic signed [ACC_W-1:0] v;
		case (i)
			0: v = ACC_W'(2949120);
			1: v = ACC_W'(1740967);
			2: v = ACC_W'(919879);
			3: v = ACC_W'(466945);
			4: v = ACC_W'(234379);
			5: v = ACC_W'(117304);
			6: v = ACC_W'(58666);
			7: v = ACC_W'(29335);
			8: v = ACC_W'(14668);
			9: v = ACC_W'(7334);
			10: v = ACC_W'(3667);
			11: v = ACC_W'(1833);
			12: v = ACC_W'(917);
			13: v = ACC_W'(458);
			14: v = ACC_W'(229);
			15: v = ACC_W'(115);
			16: v = ACC_W'(57);
			17: v = ACC_W'(29);
			18: v = ACC_W'(14);
			19: v = ACC_W'(7);
			20: v = ACC_W'(4);
			21: v = ACC_W'(2);
			22: v = ACC_W'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

	// Moves a vector in the left half plane into the right half plane.
	function automatic cord_t prerotate(input logic signed [CV_W-1:0] x,
			input logic signed [CV_W-1:0] y);
		cord_t c;
		c.x = x;
		c.y = y;
		c.a = '0;
		if (x < 0) begin
			if (y >= 0) begin
				c.x = y;
				c.y = -x;
				c.a = ACC_W'(QUARTER_TURN);
			end else begin
				c.x = -y;
				c.y = x;
				c.a = -ACC_W'(QUARTER_TURN);
			end
		end
		return c;
	endfunction

	// Rounds to 1/128 degree and limits the result to a half turn.
	function automatic logic signed [ANG_W-1:0] round_angle(input logic signed [ACC_W-1:0] a);
		logic signed [ACC_W-1:0] t;
		logic signed [ACC_W-10:0] r;
		logic signed [ANG_W-1:0] o;
		t = a + ACC_W'(256);
		r = (ACC_W-9)'(t >>> 9);
		if (r > (ACC_W-9)'(ANGLE_LIMIT)) begin
			o = ANG_W'(ANGLE_LIMIT);
		end else if (r < -(ACC_W-9)'(ANGLE_LIMIT)) begin
			o = -ANG_W'(ANGLE_LIMIT);
		end else begin
			o = ANG_W'(r);
		end
		return o;
	endfunction

endpackage

>>> src/rme_sqrt_cell.sv
// One cell of the digit-by-digit square root chain, producing one root bit.
// Depends on rme_pkg.
`timescale 1ns / 1ps

module rme_sqrt_cell #(
	parameter int K = 0
) (
	input logic clk,
	input logic en,
	input rme_pkg::sq_t din,
	output rme_pkg::sq_t dout
);
	import rme_pkg::*;

	logic [REM_W+1:0] rem_sh;
	logic [REM_W+1:0] trial;
	logic ge;

	always_comb begin
		rem_sh = {din.rem, din.n[2*K+1 -: 2]};
		trial = (REM_W+2)'({din.root, 2'b01});
		ge = (rem_sh >= trial);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout.n <= din.n;
			dout.rem <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
			dout.root <= {din.root[ROOT_W-2:0], ge};
		end
	end

endmodule

>>> src/rme_cordic_cell.sv
// One vectoring CORDIC micro-rotation with its angle accumulation.
// Depends on rme_pkg for the vector type and the arctangent steps.
`timescale 1ns / 1ps

module rme_cordic_cell #(
	parameter int STAGE = 0
) (
	input logic clk,
	input logic en,
	input rme_pkg::cord_t din,
	output rme_pkg::cord_t dout
);
	import rme_pkg::*;

	logic signed [CV_W-1:0] dx;
	logic signed [CV_W-1:0] dy;

	always_comb begin
		dx = din.x >>> STAGE;
		dy = din.y >>> STAGE;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (din.y >= 0) begin
				dout.x <= din.x + dy;
				dout.y <= din.y - dx;
				dout.a <= din.a + atan_step(STAGE);
			end else begin
				dout.x <= din.x - dy;
				dout.y <= din.y + dx;
				dout.a <= din.a - atan_step(STAGE);
			end
		end
	end

endmodule

>>> src/rotation_matrix_to_euler.sv
// Top level: rotation matrix to ZYX Euler angles with square root and CORDIC cell chains.
// Depends on rme_pkg, rme_sqrt_cell, rme_cordic_cell and the assertion macro header.
//
// Channel   Direction  Signals                         Content
// s_        in         s_tvalid s_tready s_tdata[111:0] matrix elements
// m_        out        m_tvalid m_tready m_tdata[47:0]  angles, m_tuser singular flag
// cfg_      in         cfg_valid cfg_ready cfg_data     singular threshold
//
// One word is taken per cycle while the output side keeps up.
// The pipeline holds 2 multiply/add stages, 24 square root cells,
// one branch select stage, the CORDIC cells, one rounding stage and the output register.
// A skid register behind the output lets one more word finish while m_tready is low;
// with it full the whole chain holds. Reset clears all valid flags, the threshold is 1.
`timescale 1ns / 1ps
`include "rotation_matrix_to_euler_macros.svh"

module rotation_matrix_to_euler #(
	parameter int CORDIC_STAGES = 16
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [111:0] s_tdata, // m11, m21, m31, m32, m33, m22, m23
	output logic m_tvalid,
	input logic m_tready,
	output logic [47:0] m_tdata, // angle_x, angle_y, angle_z
	output logic m_tuser, // is_singular
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [14:0] cfg_data
);
	import rme_pkg::*;

	localparam int NS = ROOT_W;
	localparam int NL = 3;

	logic en;
	logic [14:0] thr_q;

	elems_t el_s1;
	logic signed [2*ELEM_W-1:0] p11_s1;
	logic signed [2*ELEM_W-1:0] p21_s1;
	logic v_s1;

	sq_t sq_q [NS+1];
	elems_t el_q [NS+1];
	logic v_q [NS+1];

	logic [ROOT_W-1:0] sy;
	logic sing;
	logic signed [CV_W-1:0] lx [NL];
	logic signed [CV_W-1:0] ly [NL];

	cord_t cd_q [NL][CORDIC_STAGES+1];
	logic [NL-1:0] zf_q [CORDIC_STAGES+1];
	logic sg_q [CORDIC_STAGES+1];
	logic cv_q [CORDIC_STAGES+1];

	res_t r_s4;
	logic v_s4;
	res_t o_q;
	logic ov_q;
	res_t sk_q;
	logic skv_q;
	logic take;

	assign en = !skv_q;
	assign s_tready = en;
	assign cfg_ready = 1'b1;
	assign take = ov_q && m_tready;
	assign m_tvalid = ov_q;
	assign m_tdata = {o_q.az, o_q.ay, o_q.ax};
	assign m_tuser = o_q.sing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 15'd1;
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			el_s1 <= elems_t'(s_tdata);
			p11_s1 <= $signed(s_tdata[15:0]) * $signed(s_tdata[15:0]);
			p21_s1 <= $signed(s_tdata[31:16]) * $signed(s_tdata[31:16]);
			el_q[0] <= el_s1;
			sq_q[0].n <= {32'(p11_s1) + 32'(p21_s1), 16'b0};
			sq_q[0].rem <= '0;
			sq_q[0].root <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_q[0] <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_q[0] <= v_s1;
		end
	end

	for (genvar j = 0; j < NS; j++) begin : g_sqrt
		rme_sqrt_cell #(.K(NS - 1 - j)) u_cell (
			.clk(clk),
			.en(en),
			.din(sq_q[j]),
			.dout(sq_q[j+1])
		);

		always_ff @(posedge clk) begin
			if (en) begin
				el_q[j+1] <= el_q[j];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[j+1] <= 1'b0;
			end else if (en) begin
				v_q[j+1] <= v_q[j];
			end
		end
	end

	always_comb begin
		sy = sq_q[NS].root;
		sing = (sy < ROOT_W'({thr_q, 8'b0}));
		if (sing) begin
			ly[0] = -(CV_W'(el_q[NS].m23) <<< 8);
			lx[0] = CV_W'(el_q[NS].m22) <<< 8;
		end else begin
			ly[0] = CV_W'(el_q[NS].m32) <<< 8;
			lx[0] = CV_W'(el_q[NS].m33) <<< 8;
		end
		ly[1] = -(CV_W'(el_q[NS].m31) <<< 8);
		lx[1] = CV_W'({1'b0, sy});
		ly[2] = CV_W'(el_q[NS].m21) <<< 8;
		lx[2] = CV_W'(el_q[NS].m11) <<< 8;
	end

	for (genvar l = 0; l < NL; l++) begin : g_lane
		always_ff @(posedge clk) begin
			if (en) begin
				cd_q[l][0] <= prerotate(lx[l], ly[l]);
				zf_q[0][l] <= (lx[l] == 0) && (ly[l] == 0);
			end
		end

		for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_stage
			rme_cordic_cell #(.STAGE(j)) u_cell (
				.clk(clk),
				.en(en),
				.din(cd_q[l][j]),
				.dout(cd_q[l][j+1])
			);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sg_q[0] <= sing;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_q[0] <= 1'b0;
		end else if (en) begin
			cv_q[0] <= v_q[NS];
		end
	end

	for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_flags
		always_ff @(posedge clk) begin
			if (en) begin
				zf_q[j+1] <= zf_q[j];
				sg_q[j+1] <= sg_q[j];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_q[j+1] <= 1'b0;
			end else if (en) begin
				cv_q[j+1] <= cv_q[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s4.ax <= zf_q[CORDIC_STAGES][0] ? '0 : round_angle(cd_q[0][CORDIC_STAGES].a);
			r_s4.ay <= zf_q[CORDIC_STAGES][1] ? '0 : round_angle(cd_q[1][CORDIC_STAGES].a);
			r_s4.az <= (zf_q[CORDIC_STAGES][2] || sg_q[CORDIC_STAGES]) ? '0 :
				round_angle(cd_q[2][CORDIC_STAGES].a);
			r_s4.sing <= sg_q[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= cv_q[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			skv_q <= 1'b0;
		end else if (skv_q) begin
			if (take) begin
				skv_q <= 1'b0;
			end
		end else if (v_s4) begin
			if (ov_q && !take) begin
				skv_q <= 1'b1;
			end else begin
				ov_q <= 1'b1;
			end
		end else if (take) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skv_q) begin
			if (take) begin
				o_q <= sk_q;
			end
		end else if (v_s4) begin
			if (ov_q && !take) begin
				sk_q <= r_s4;
			end else begin
				o_q <= r_s4;
			end
		end
	end

	`RME_ASSERT_IMP(a_skid_needs_out, skv_q, ov_q)
	`RME_ASSERT_IMP(a_sing_zero_z, ov_q && o_q.sing, o_q.az == '0)
	`RME_ASSERT_IMP(a_x_in_range, ov_q,
		(o_q.ax <= ANG_W'(ANGLE_LIMIT)) && (o_q.ax >= -ANG_W'(ANGLE_LIMIT)))
	`RME_ASSERT_NEXT(a_skid_fill, !skv_q && v_s4 && ov_q && !m_tready, skv_q)

endmodule

>>> dv/tb_rotation_matrix_to_euler.sv
// Self-checking testbench of the rotation matrix to ZYX Euler angle block.
// It predicts every output word from the accepted matrix word and the threshold register.
// Depends on rme_pkg and rotation_matrix_to_euler.
`timescale 1ns / 1ps

module tb_rotation_matrix_to_euler;
	import rme_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam int SETTLE = 60;
	localparam longint HALF_TURN = 23040;
	localparam longint RIGHT_ANGLE = 90 * 65536;
	localparam longint ARC_STEP [24] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0};

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [111:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [47:0] m_tdata;
	logic m_tuser;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [14:0] cfg_data = '0;

	elems_t matrix_q[$];
	res_t euler_q[$];
	logic [14:0] threshold = 15'd1;
	int send_idle = 0;
	int recv_idle = 0;
	int hold_left = 0;
	int mismatches = 0;
	int quiet_cycles = 0;

	rotation_matrix_to_euler #(.CORDIC_STAGES(16)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	function automatic longint floor_sqrt(input longint n);
		longint root;
		longint b;
		root = 0;
		b = 64'sd1 <<< 62;
		while (b > n) b = b >>> 2;
		while (b != 0) begin
			if (n >= root + b) begin
				n = n - (root + b);
				root = (root >>> 1) + b;
			end else begin
				root = root >>> 1;
			end
			b = b >>> 2;
		end
		return root;
	endfunction

	function automatic logic signed [15:0] arc_deg128(input longint y, input longint x);
		longint acc;
		longint t;
		longint dx;
		longint dy;
		acc = 0;
		if (x == 0 && y == 0) return 16'sd0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y;
				y = -t;
				acc = RIGHT_ANGLE;
			end else begin
				x = -y;
				y = t;
				acc = -RIGHT_ANGLE;
			end
		end
		for (int i = 0; i < 16; i++) begin
			dx = x >>> i;
			dy = y >>> i;
			if (y >= 0) begin
				x = x + dy;
				y = y - dx;
				acc = acc + ARC_STEP[i];
			end else begin
				x = x - dy;
				y = y + dx;
				acc = acc - ARC_STEP[i];
			end
		end
		acc = (acc + 256) >>> 9;
		if (acc > HALF_TURN) acc = HALF_TURN;
		if (acc < -HALF_TURN) acc = -HALF_TURN;
		return 16'(acc);
	endfunction

	function automatic res_t euler_of(input elems_t e, input logic [14:0] thr);
		res_t r;
		longint a11;
		longint a21;
		longint sy;
		a11 = longint'(e.m11);
		a21 = longint'(e.m21);
		sy = floor_sqrt((a11 * a11 + a21 * a21) <<< 16);
		r.sing = sy < (longint'(thr) <<< 8);
		r.ay = arc_deg128(-longint'(e.m31) * 256, sy);
		if (!r.sing) begin
			r.ax = arc_deg128(longint'(e.m32) * 256, longint'(e.m33) * 256);
			r.az = arc_deg128(a21 * 256, a11 * 256);
		end else begin
			r.ax = arc_deg128(-longint'(e.m23) * 256, longint'(e.m22) * 256);
			r.az = '0;
		end
		return r;
	endfunction

	function automatic elem_t pick_elem(input bit near_zero);
		int sel;
		elem_t edge_vals [4];
		edge_vals = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff};
		sel = $urandom_range(0, 9);
		if (near_zero) return elem_t'($urandom_range(0, 800) - 400);
		if (sel == 0) return edge_vals[$urandom_range(0, 3)];
		return elem_t'($urandom);
	endfunction

	function automatic elems_t random_matrix();
		elems_t e;
		bit near_zero;
		near_zero = ($urandom_range(0, 9) < 3);
		e.m11 = pick_elem(near_zero);
		e.m21 = pick_elem(near_zero);
		e.m31 = pick_elem(0);
		e.m32 = pick_elem(0);
		e.m33 = pick_elem(0);
		e.m22 = pick_elem(0);
		e.m23 = pick_elem(0);
		return e;
	endfunction

	always @(posedge clk) begin
		logic nxt_valid;
		elems_t nxt_data;
		if (arst_n) begin
			nxt_valid = s_tvalid;
			nxt_data = s_tdata;
			if (s_tvalid && s_tready) begin
				euler_q.push_back(euler_of(elems_t'(s_tdata), threshold));
				nxt_valid = 0;
			end
			if (!nxt_valid && matrix_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
				nxt_data = matrix_q.pop_front();
				nxt_valid = 1;
			end
			s_tvalid <= nxt_valid;
			s_tdata <= nxt_data;
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (euler_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected word %h sing %b", m_tdata, m_tuser);
				end else begin
					want = euler_q.pop_front();
					if (m_tdata[15:0] !== want.ax || m_tdata[31:16] !== want.ay ||
							m_tdata[47:32] !== want.az || m_tuser !== want.sing) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected x %0d y %0d z %0d s %b, got x %0d y %0d z %0d s %b",
								want.ax, want.ay, want.az, want.sing,
								$signed(m_tdata[15:0]), $signed(m_tdata[31:16]),
								$signed(m_tdata[47:32]), m_tuser);
					end
				end
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_idle);
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb_rotation_matrix_to_euler: errors");
				$finish;
			end
		end
	end

	task automatic drain();
		while (matrix_q.size() > 0 || s_tvalid || euler_q.size() > 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [14:0] v);
		cfg_valid <= 1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		threshold = v;
		@(posedge clk);
	endtask

	task automatic load_random(input int n);
		repeat (n) matrix_q.push_back(random_matrix());
	endtask

	task automatic push_matrix(input int a, b, c, d, f, g, h);
		elems_t e;
		e.m11 = elem_t'(a);
		e.m21 = elem_t'(b);
		e.m31 = elem_t'(c);
		e.m32 = elem_t'(d);
		e.m33 = elem_t'(f);
		e.m22 = elem_t'(g);
		e.m23 = elem_t'(h);
		matrix_q.push_back(e);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		send_idle = 11;
		recv_idle = 49;
		push_matrix(16384, 0, 0, 0, 16384, 16384, 0);
		push_matrix(0, 0, 0, 0, 0, 0, 0);
		push_matrix(-16384, 0, 0, 0, -16384, -16384, 0);
		push_matrix(0, 16384, 0, 16384, 0, 0, -16384);
		push_matrix(0, -16384, 0, -16384, 0, 0, 16384);
		push_matrix(0, 0, -16384, 16384, 0, 16384, 0);
		push_matrix(0, 0, 16384, 0, 0, -16384, 0);
		push_matrix(0, 0, -16384, 0, 0, -16384, -32768);
		push_matrix(-32768, -32768, -32768, -32768, -32768, -32768, -32768);
		push_matrix(32767, 32767, 32767, 32767, 32767, 32767, 32767);
		push_matrix(-32768, 0, 32767, 0, -32768, -32768, 0);
		push_matrix(32767, -32768, 0, -32768, 32767, 0, 32767);
		push_matrix(-1, -1, -1, -1, -1, -1, -1);
		push_matrix(1, 0, 0, 0, 1, 1, 0);
		push_matrix(-16384, -1, 1, -1, -16384, -16384, 1);
		push_matrix(11585, 11585, 0, 11585, 11585, 11585, -11585);
		push_matrix(-11585, -11585, 16384, 0, 0, 0, 0);
		push_matrix(0, 0, 0, -32768, -32768, 0, 0);
		push_matrix(0, 0, 0, 0, 0, 0, 32767);
		drain();
		write_threshold(15'd0);
		load_random(250);
		repeat (100) @(posedge clk);
		@(negedge clk);
		hold_left = 400;
		drain();
		write_threshold(15'd16384);
		@(negedge clk);
		send_idle = 49;
		recv_idle = 11;
		load_random(250);
		drain();
		write_threshold(15'd32767);
		load_random(250);
		drain();
		@(negedge clk);
		send_idle = 0;
		recv_idle = 0;
		write_threshold(15'($urandom_range(1, 600)));
		load_random(250);
		drain();
		write_threshold(15'd1);
		load_random(450);
		drain();
		if (mismatches == 0 && euler_q.size() == 0)
			$display("tb_rotation_matrix_to_euler: clean");
		else
			$display("tb_rotation_matrix_to_euler: errors");
		$finish;
	end

endmodule
